[sv/ipv4_dotted_text_parser_unit_macros.svh]
// Assertion macros shared by the dotted-decimal address parser.
`ifndef IPV4_DOTTED_TEXT_PARSER_UNIT_MACROS_SVH
`define IPV4_DOTTED_TEXT_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk, disabled during reset.
`define IPDTP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, disabled during reset.
`define IPDTP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/ipdtp_pkg.sv]
// Types and constants of the dotted-decimal address parser.
package ipdtp_pkg;

	localparam int MaxChars       = 15;
	localparam int CharCountWidth = $clog2(MaxChars + 2);

	localparam logic [7:0] CharZero = 8'h30;
	localparam logic [7:0] CharNine = 8'h39;
	localparam logic [7:0] CharDot  = 8'h2E;

	localparam logic [1:0] DotsNeeded = 2'd3;
	localparam logic [1:0] MaxDigits  = 2'd3;

	typedef struct packed {
		logic [23:0]               done_octets;
		logic [7:0]                octet_accum;
		logic [1:0]                digit_count;
		logic [1:0]                dot_count;
		logic [CharCountWidth-1:0] char_count;
		logic                      prev_was_dot;
		logic                      format_error;
	} parse_state_t;

	typedef struct packed {
		logic [31:0] address;
		logic        format_ok;
	} parse_result_t;

endpackage

[sv/ipdtp_text_if.sv]
// Character request channel of the address parser.
interface ipdtp_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

[sv/ipdtp_result_if.sv]
// Result request channel of the address parser.
interface ipdtp_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] address;
	logic        format_ok;

	modport source (output valid, output address, output format_ok, input ready);
	modport sink   (input valid, input address, input format_ok, output ready);
endinterface

[sv/ipdtp_step.sv]
// Per-character update of the parser state and the result it would give.
module ipdtp_step (
	input  ipdtp_pkg::parse_state_t  state,
	input  logic [7:0]               char_code,
	input  logic                     last_char,
	output ipdtp_pkg::parse_state_t  next_state,
	output ipdtp_pkg::parse_result_t result
);

	logic                                      first;
	logic                                      is_digit;
	logic [7:0]                                accum_x10;
	logic [23:0]                               octet_placed;
	logic [ipdtp_pkg::CharCountWidth-1:0]      count_limit;

	assign first       = (state.char_count == '0);
	assign count_limit = ipdtp_pkg::CharCountWidth'(ipdtp_pkg::MaxChars);
	assign accum_x10   = {state.octet_accum[4:0], 3'b000} + {state.octet_accum[6:0], 1'b0};
	assign octet_placed = {16'h0000, state.octet_accum} << {state.dot_count, 3'b000};

	always_comb begin
		is_digit   = char_code inside {[ipdtp_pkg::CharZero:ipdtp_pkg::CharNine]};
		next_state = state;

		if (state.char_count <= count_limit) begin
			next_state.char_count = state.char_count + ipdtp_pkg::CharCountWidth'(1);
		end
		if (next_state.char_count > count_limit) begin
			next_state.format_error = 1'b1;
		end

		if (is_digit) begin
			if (state.digit_count >= ipdtp_pkg::MaxDigits) begin
				next_state.format_error = 1'b1;
			end else begin
				next_state.digit_count = state.digit_count + 2'd1;
			end
			next_state.octet_accum  = accum_x10 + {4'h0, char_code[3:0]};
			next_state.prev_was_dot = 1'b0;
		end else if (char_code == ipdtp_pkg::CharDot) begin
			if (first || state.prev_was_dot || last_char) begin
				next_state.format_error = 1'b1;
			end
			if (state.dot_count >= ipdtp_pkg::DotsNeeded) begin
				next_state.format_error = 1'b1;
			end else begin
				next_state.done_octets = state.done_octets | octet_placed;
				next_state.dot_count   = state.dot_count + 2'd1;
			end
			next_state.octet_accum  = '0;
			next_state.digit_count  = '0;
			next_state.prev_was_dot = 1'b1;
		end else begin
			next_state.format_error = 1'b1;
			next_state.prev_was_dot = 1'b0;
		end

		result.format_ok = !next_state.format_error
			&& (next_state.dot_count == ipdtp_pkg::DotsNeeded);
		result.address   = result.format_ok
			? {next_state.octet_accum, next_state.done_octets} : 32'h0;
	end

endmodule

[sv/ipv4_dotted_text_parser_unit.sv]
// Dotted-decimal IPv4 text parser: one character in per cycle, the
// 32-bit address out at the final character. Each accepted character is
// held in an input register, runs through the combinational update logic and
// updates the parse state; the final character loads the result register, so
// a result is offered once its last character has passed the input register
// and the result register, held back while an earlier result is still waiting
// to be taken. The block takes one character every cycle and stalls only
// when a final character meets a result still waiting to be taken. The
// first octet lands in address bits 7:0; rejected text gives address 0 with
// format_ok low. State clears after every text.
module ipv4_dotted_text_parser_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	ipdtp_text_if.sink             text,
	ipdtp_result_if.source         result
);

	`include "ipv4_dotted_text_parser_unit_macros.svh"

	logic                      valid_s1;
	logic [7:0]                char_s1;
	logic                      last_s1;
	logic                      advance;
	ipdtp_pkg::parse_state_t   state_q;
	ipdtp_pkg::parse_state_t   next_state;
	ipdtp_pkg::parse_result_t  step_result;
	logic                      out_valid_q;
	ipdtp_pkg::parse_result_t  out_q;

	assign advance    = valid_s1 && (!last_s1 || !out_valid_q || result.ready);
	assign text.ready = !valid_s1 || advance;

	ipdtp_step u_step (
		.state      (state_q),
		.char_code  (char_s1),
		.last_char  (last_s1),
		.next_state (next_state),
		.result     (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (text.ready) begin
				valid_s1 <= text.valid;
			end
			if (advance) begin
				state_q <= last_s1 ? '0 : next_state;
			end
			if (advance && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			char_s1 <= text.char_code;
			last_s1 <= text.last_char;
		end
		if (advance && last_s1) begin
			out_q <= step_result;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.address   = out_q.address;
	assign result.format_ok = out_q.format_ok;

	`IPDTP_ASSERT_NOW(a_reject_zero,
		out_valid_q && !out_q.format_ok, out_q.address == 32'h0,
		"rejected text with non-zero address")
	`IPDTP_ASSERT_NEXT(a_last_gives_result,
		advance && last_s1, out_valid_q,
		"final character without result")
	`IPDTP_ASSERT_NEXT(a_state_cleared,
		advance && last_s1, state_q == '0,
		"state not cleared after text")
	`IPDTP_ASSERT_NEXT(a_stall_holds,
		valid_s1 && !advance, valid_s1 && last_s1 && $stable(char_s1),
		"stalled character lost")

endmodule
